@@ hw/rtl/bpa_pkg.sv @@
package bpa_pkg;

    localparam int NUM_PAGES_DEF = 1024;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TOO_BIG = 2'd1;
    localparam logic [1:0] ST_NO_RUN  = 2'd2;
    localparam logic [1:0] ST_BAD_ADR = 2'd3;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // register indexes
    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_AVAIL = 2'd1;
    localparam logic [1:0] REG_PAGE  = 2'd2;
    localparam logic [1:0] REG_RSVD  = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // capture the transaction
        logic div_start; // start the divider
        logic clr_init;  // clearing pass step
        logic scan_init; // start scan at hint
        logic scan_step; // advance scan
        logic mark_step; // write one bit of a run
        logic mark_init; // set up mark/free loop
        logic hint_upd;  // update hint after a grant
        logic fhint_upd; // update hint after a free
        logic mul_start; // granted address product
        logic res_load;  // load result register
    } bpa_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_free;
        logic too_big;
        logic bad_adr;
        logic div_done;
        logic run_big;   // pages above map size
        logic found;
        logic scan_end;
        logic mark_end;
        logic clr_end;
    } bpa_sts_t;

endpackage

@@ hw/rtl/bpa_ram.sv @@
module bpa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/bpa_div.sv @@
module bpa_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic [31:0] quotient,
    output logic        rem_nz,
    output logic        done
);

    logic [31:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [15:0] d_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [16:0] trial;

    // restoring division, one quotient bit per cycle
    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[15:0], q_reg[31]};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[30:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        if (start) begin
            d_reg <= divisor;
        end
    end

    assign quotient = q_reg;
    assign rem_nz   = (r_reg != '0);
    assign done     = !busy_reg;

endmodule

@@ hw/rtl/bpa_datapath.sv @@
module bpa_datapath
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  bpa_cmd_t    cmd,
    output bpa_sts_t    sts,
    input  logic        s_operation,
    input  logic [31:0] s_byte_count,
    input  logic [31:0] s_free_address,
    input  logic [31:0] base_address,
    input  logic [31:0] available_bytes,
    input  logic [15:0] page_bytes,
    input  logic [10:0] reserved_pages,
    output logic [31:0] res_address,
    output logic [1:0]  res_status
);

    localparam int AW = $clog2(NUM_PAGES);
    localparam int PW = AW + 1;

    logic          op_reg;
    logic [31:0]   bytes_reg, addr_reg;
    logic [15:0]   pg;
    logic [PW-1:0] rsv;
    logic [PW-1:0] hint_reg, hint_next;
    logic [PW-1:0] ehint;
    logic [31:0]   pages_reg;
    logic [PW-1:0] idx_reg;       // free start page
    logic [PW-1:0] scan_reg;      // next page address to read
    logic [PW-1:0] run_len_reg;   // free pages seen in current run
    logic [PW-1:0] run_at_reg;
    logic          wrapped_reg;   // read address is in the second pass
    logic          ev_wrap_reg;   // page under test is in the second pass
    logic          iss_end_reg;   // no more addresses to read
    logic          scan_end_reg;  // search finished without a run
    logic          rd_valid_reg;  // ram output corresponds to scan_prev
    logic [PW-1:0] scan_prev_reg;
    logic [PW-1:0] mk_reg;        // mark/free pointer
    logic [PW-1:0] mk_end_reg;
    logic [PW-1:0] clr_reg;
    logic          found_reg;
    logic [31:0]   prod_reg;
    logic [31:0]   res_addr_reg;
    logic [1:0]    res_st_reg;
    logic          div_phase_reg; // 0 size, 1 address

    logic          ram_we;
    logic [AW-1:0] ram_wa, ram_ra;
    logic          ram_wd, ram_rd;
    logic [31:0]   div_dvd, div_q;
    logic          div_rnz, div_done;
    logic [32:0]   hi_sum;
    logic          busy_bit;
    logic [31:0]   need;
    logic          hit;
    logic          ev_last;
    logic          ev_past;

    assign pg  = (page_bytes == '0) ? 16'd1 : page_bytes;
    assign rsv = ({5'd0, reserved_pages} > NUM_PAGES) ? PW'(NUM_PAGES)
                                                      : PW'(reserved_pages);
    assign ehint = (hint_reg > rsv) ? hint_reg : rsv;
    assign hi_sum = {1'b0, base_address} + {1'b0, available_bytes};

    // dividend: raised size for allocate, byte count then offset for free
    always_comb begin
        if (op_reg == OP_ALLOC) begin
            div_dvd = (bytes_reg < {16'd0, pg}) ? {16'd0, pg} : bytes_reg;
        end else if (!div_phase_reg) begin
            div_dvd = bytes_reg;
        end else begin
            div_dvd = addr_reg - base_address;
        end
    end

    bpa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (pg),
        .quotient (div_q),
        .rem_nz   (div_rnz),
        .done     (div_done)
    );

    bpa_ram #(.WIDTH(1), .DEPTH(NUM_PAGES)) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_wa),
        .wdata (ram_wd),
        .raddr (ram_ra),
        .rdata (ram_rd)
    );

    // ram write: clearing pass, mark or free
    always_comb begin
        ram_we = 1'b0;
        ram_wa = clr_reg[AW-1:0];
        ram_wd = 1'b0;
        if (cmd.clr_init) begin
            ram_we = 1'b1;
        end else if (cmd.mark_step && (mk_reg < mk_end_reg)) begin
            ram_we = 1'b1;
            ram_wa = mk_reg[AW-1:0];
            ram_wd = (op_reg == OP_ALLOC);
        end
    end
    assign ram_ra   = scan_reg[AW-1:0];
    assign busy_bit = (scan_prev_reg < rsv) || ram_rd;
    assign need     = pages_reg;

    // page under test completes a long enough run
    assign hit = rd_valid_reg && !busy_bit &&
                 (({1'b0, 31'(run_len_reg)} + 32'd1) >= need);
    // last page of the final pass
    assign ev_last = (scan_prev_reg == PW'(NUM_PAGES - 1)) &&
                     (ev_wrap_reg || ehint == '0);
    // second pass at or past the hint with no run alive from below it
    assign ev_past = ev_wrap_reg && (scan_prev_reg >= ehint) &&
                     (busy_bit || run_len_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hint_reg      <= '0;
            clr_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            scan_end_reg  <= 1'b0;
            div_phase_reg <= 1'b0;
        end else begin
            hint_reg <= hint_next;
            if (cmd.clr_init) begin
                clr_reg <= clr_reg + PW'(1);
            end
            // divider sequencing for free: size first, then offset
            if (cmd.load) begin
                div_phase_reg <= 1'b0;
            end else if (cmd.div_start && op_reg == OP_FREE) begin
                div_phase_reg <= 1'b1;
            end
            if (cmd.load || cmd.scan_init) begin
                rd_valid_reg <= 1'b0;
                found_reg    <= 1'b0;
                scan_end_reg <= 1'b0;
            end else if (cmd.scan_step && !found_reg && !scan_end_reg) begin
                rd_valid_reg <= !iss_end_reg;
                if (hit) begin
                    found_reg <= 1'b1;
                end else if (rd_valid_reg && (ev_last || ev_past)) begin
                    scan_end_reg <= 1'b1;
                end
            end
        end
    end

    // hint updates
    always_comb begin
        hint_next = hint_reg;
        if (cmd.hint_upd && (run_at_reg == ehint)) begin
            hint_next = PW'(run_at_reg + pages_reg[PW-1:0]);
        end else if (cmd.fhint_upd && (idx_reg < ehint)) begin
            hint_next = idx_reg;
        end
    end

    // scan: from the hint to the map end, then from page zero; run_len counts
    // free pages ending at scan_prev and restarts at the map end
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_operation;
            bytes_reg <= s_byte_count;
            addr_reg  <= s_free_address;
        end
        if (div_done && !cmd.load) begin
            if (op_reg == OP_ALLOC) begin
                if (!cmd.div_start) begin
                    pages_reg <= div_q + {31'd0, div_rnz};
                end
            end else if (div_phase_reg) begin
                // size quotient is final when the offset division starts
                if (cmd.div_start) begin
                    pages_reg <= div_q + {31'd0, div_rnz};
                end else begin
                    idx_reg <= (div_q >= NUM_PAGES) ? PW'(NUM_PAGES) : PW'(div_q);
                end
            end
        end
        if (cmd.scan_init) begin
            // hint at the map end: only the pass from page zero remains
            scan_reg    <= (ehint == PW'(NUM_PAGES)) ? '0 : ehint;
            wrapped_reg <= (ehint == PW'(NUM_PAGES));
            iss_end_reg <= 1'b0;
            run_len_reg <= '0;
        end else if (cmd.scan_step && !found_reg && !scan_end_reg) begin
            scan_prev_reg <= scan_reg;
            ev_wrap_reg   <= wrapped_reg;
            if (rd_valid_reg) begin
                if (hit) begin
                    run_at_reg <= PW'(scan_prev_reg - run_len_reg);
                end else if (busy_bit || scan_prev_reg == PW'(NUM_PAGES - 1)) begin
                    run_len_reg <= '0;
                end else begin
                    run_len_reg <= run_len_reg + PW'(1);
                end
            end
            // advance address; wrap to zero once after the map end
            if (!iss_end_reg) begin
                if (scan_reg == PW'(NUM_PAGES - 1)) begin
                    if (!wrapped_reg && ehint != '0) begin
                        scan_reg    <= '0;
                        wrapped_reg <= 1'b1;
                    end else begin
                        iss_end_reg <= 1'b1;
                    end
                end else begin
                    scan_reg <= scan_reg + PW'(1);
                end
            end
        end
        if (cmd.mark_init) begin
            if (op_reg == OP_ALLOC) begin
                mk_reg     <= run_at_reg;
                mk_end_reg <= PW'(run_at_reg + pages_reg[PW-1:0]);
            end else begin
                mk_reg <= idx_reg;
                mk_end_reg <= (({1'b0, pages_reg} + 33'(idx_reg)) >= 33'(NUM_PAGES))
                              ? PW'(NUM_PAGES) : PW'(idx_reg + pages_reg[PW-1:0]);
            end
        end else if (cmd.mark_step) begin
            mk_reg <= mk_reg + PW'(1);
        end
        if (cmd.mul_start) begin
            prod_reg <= 32'(run_at_reg) * {16'd0, pg};
        end
        if (cmd.res_load) begin
            if (op_reg == OP_ALLOC && bytes_reg > available_bytes) begin
                res_st_reg   <= ST_TOO_BIG;
                res_addr_reg <= '0;
            end else if (op_reg == OP_FREE) begin
                res_st_reg   <= sts.bad_adr ? ST_BAD_ADR : ST_OK;
                res_addr_reg <= '0;
            end else if (!found_reg) begin
                res_st_reg   <= ST_NO_RUN;
                res_addr_reg <= '0;
            end else begin
                res_st_reg   <= ST_OK;
                res_addr_reg <= base_address + prod_reg;
            end
        end
    end

    assign sts.is_free  = (op_reg == OP_FREE);
    assign sts.too_big  = (bytes_reg > available_bytes);
    assign sts.bad_adr  = (addr_reg < base_address) || ({1'b0, addr_reg} >= hi_sum);
    assign sts.div_done = div_done;
    // page count straight from the divider, valid once it is done
    assign sts.run_big  = (({1'b0, div_q} + {32'd0, div_rnz}) > 33'(NUM_PAGES));
    assign sts.found    = found_reg;
    assign sts.scan_end = scan_end_reg;
    assign sts.mark_end = (mk_reg >= mk_end_reg);
    assign sts.clr_end  = (clr_reg == PW'(NUM_PAGES));

    assign res_address = res_addr_reg;
    assign res_status  = res_st_reg;

endmodule

@@ hw/rtl/bpa_ctrl.sv @@
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output bpa_cmd_t cmd,
    input  bpa_sts_t sts
);

    typedef enum logic [11:0] {
        S_CLEAR = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_CHECK = 12'b000000000100,
        S_DIV   = 12'b000000001000,
        S_DIV2  = 12'b000000010000,
        S_SCANI = 12'b000000100000,
        S_SCAN  = 12'b000001000000,
        S_MARKI = 12'b000010000000,
        S_MARK  = 12'b000100000000,
        S_MUL   = 12'b001000000000,
        S_RES   = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic   started_reg, started_next;

    // sequencer: check, divide, scan, mark, multiply, respond
    always_comb begin
        state_next   = state_reg;
        started_next = started_reg;
        cmd          = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_init = 1'b1;
                if (sts.clr_end) begin
                    cmd.clr_init = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if ((!sts.is_free && sts.too_big) || (sts.is_free && sts.bad_adr)) begin
                    state_next = S_RES;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                if (sts.div_done) begin
                    if (sts.is_free) begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV2;
                    end else if (sts.run_big) begin
                        state_next = S_RES;
                    end else begin
                        state_next = S_SCANI;
                    end
                end
            end
            S_DIV2: begin
                if (sts.div_done) begin
                    started_next = 1'b0;
                    state_next   = S_MARKI;
                end
            end
            S_SCANI: begin
                cmd.scan_init = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.found) begin
                    cmd.scan_step = 1'b0;
                    state_next    = S_MARKI;
                end else if (sts.scan_end) begin
                    cmd.scan_step = 1'b0;
                    state_next    = S_RES;
                end
            end
            S_MARKI: begin
                cmd.mark_init = 1'b1;
                state_next    = S_MARK;
            end
            S_MARK: begin
                cmd.mark_step = 1'b1;
                if (sts.mark_end) begin
                    cmd.mark_step = 1'b0;
                    if (sts.is_free) begin
                        cmd.fhint_upd = 1'b1;
                        state_next    = S_RES;
                    end else begin
                        cmd.hint_upd  = 1'b1;
                        cmd.mul_start = 1'b1;
                        state_next    = S_MUL;
                    end
                end
            end
            S_MUL: begin
                state_next = S_RES;
            end
            S_RES: begin
                cmd.res_load = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            started_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            started_reg <= started_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE) && !started_reg;
    assign m_valid = (state_reg == S_OUT);

`ifndef SYNTHESIS
    a_one_hot: assert property (@(posedge aclk) disable iff (!aresetn) $onehot(state_reg))
        else $error("state not one-hot");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn) !(s_ready && m_valid))
        else $error("input accepted while result pending");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transaction");
`endif

endmodule

@@ hw/rtl/bitmap_page_allocator.sv @@
// Bitmap next-fit page allocator. Each transaction on the s_ channel either
// allocates (operation 0) a run of pages big enough for byte_count, or frees
// (operation 1) the run at free_address; exactly one result transaction follows
// on the m_ channel with granted_address and status. One transaction is
// processed at a time: a page-size division, one quotient bit per cycle (a
// free divides twice, size then offset), then for an allocate a scan of the
// page map, one page per cycle, from the search hint to the map end and then
// from page zero, and then the pages of the run are marked or freed, page by
// page. After reset the page map is swept clear, one page per cycle, before
// the first transaction is taken; register writes through the APB port are
// accepted at any time.
module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [31:0] s_byte_count,
    input  logic [31:0] s_free_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_granted_address,
    output logic [1:0]  m_status
);

    logic [31:0] base_reg, avail_reg;
    logic [15:0] page_reg;
    logic [10:0] rsvd_reg;
    bpa_cmd_t    cmd;
    bpa_sts_t    sts;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            avail_reg <= '0;
            page_reg  <= 16'd4096;
            rsvd_reg  <= 11'd1;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_BASE:  base_reg  <= pwdata;
                REG_AVAIL: avail_reg <= pwdata;
                REG_PAGE:  page_reg  <= pwdata[15:0];
                REG_RSVD:  rsvd_reg  <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb begin
        unique case (paddr[3:2])
            REG_BASE:  prdata = base_reg;
            REG_AVAIL: prdata = avail_reg;
            REG_PAGE:  prdata = {16'd0, page_reg};
            REG_RSVD:  prdata = {21'd0, rsvd_reg};
            default:   prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    bpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    bpa_datapath #(.NUM_PAGES(NUM_PAGES)) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_operation     (s_operation),
        .s_byte_count    (s_byte_count),
        .s_free_address  (s_free_address),
        .base_address    (base_reg),
        .available_bytes (avail_reg),
        .page_bytes      (page_reg),
        .reserved_pages  (rsvd_reg),
        .res_address     (m_granted_address),
        .res_status      (m_status)
    );

endmodule
